### design/epmc_pkg.sv
`timescale 1ns / 1ps

package epmc_pkg;

  // Command codes carried in the cmd field
  localparam logic [2:0] CMD_ENC_EDGE  = 3'd0;
  localparam logic [2:0] CMD_RUN_TICK  = 3'd1;
  localparam logic [2:0] CMD_MOVE_ABS  = 3'd2;
  localparam logic [2:0] CMD_MOVE_REL  = 3'd3;
  localparam logic [2:0] CMD_GO_MIN    = 3'd4;
  localparam logic [2:0] CMD_GO_MAX    = 3'd5;
  localparam logic [2:0] CMD_RESET_POS = 3'd6;
  localparam logic [2:0] CMD_STOP      = 3'd7;

  // Configuration register indexes
  localparam logic [2:0] REG_MIN_POSITION = 3'd0;
  localparam logic [2:0] REG_MAX_POSITION = 3'd1;
  localparam logic [2:0] REG_DEADBAND     = 3'd2;
  localparam logic [2:0] REG_RUN_SPEED    = 3'd3;
  localparam logic [2:0] REG_MIN_DUTY     = 3'd4;
  localparam logic [2:0] REG_MAX_DUTY     = 3'd5;

  // Duty requested on the first drive tick after a stop, reset or settle, before the duty limits
  localparam logic [7:0] KICK_DUTY = 8'd255;

  typedef struct packed {
    logic [2:0]          cmd;
    logic                encoder_b;
    logic signed [15:0]  value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]          duty_forward;
    logic [7:0]          duty_reverse;
    logic signed [15:0]  position;
    logic                at_target;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0]  min_position;
    logic signed [15:0]  max_position;
    logic [14:0]         deadband;
    logic [7:0]          run_speed;
    logic [7:0]          min_duty;
    logic [7:0]          max_duty;
  } cfg_t;

endpackage

### design/encoder_position_motor_controller_core.sv
`timescale 1ns / 1ps

// Channel  | Ports                              | Moves
// ---------+------------------------------------+-------------------------------
// input    | in_valid, in_ready, in_item        | one command per transaction
// result   | out_valid, out_ready, out_item     | one result per command
// config   | cfg_valid, cfg_ready, cfg_index,   | one register write
//          | cfg_data                           |
//
// A command is captured in the input register, evaluated against the controller
// state when it moves on, and its result is registered in the result register,
// which drives out_valid; one command per cycle is sustained while out_ready
// stays high.
// Synchronous active-low reset clears both stage valids and the controller state.
// A stalled result holds the result register; the input register still takes a
// new command whenever its contents can move on in the same cycle.
// Config writes are always taken (cfg_ready is tied high).

module encoder_position_motor_controller_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  epmc_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output epmc_pkg::out_item_t  out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data
);
  import epmc_pkg::*;

  logic      s1_valid_r,  s1_valid_nxt;
  in_item_t  s1_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;
  out_item_t result;
  cfg_t      cfg;
  logic      in_fire;
  logic      out_free;
  logic      s1_fire;

  assign cfg_ready = 1'b1;

  epmc_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  epmc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .item_en (s1_fire),
    .item    (s1_item_r),
    .cfg     (cfg),
    .result  (result)
  );

  // Handshake between the two stages
  assign out_free = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_item;
    end
    if (s1_fire) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### design/epmc_cfg_regs.sv
`timescale 1ns / 1ps

module epmc_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [2:0]        wr_index,
  input  logic [15:0]       wr_data,
  output epmc_pkg::cfg_t    cfg
);
  import epmc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the register write
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_MIN_POSITION: cfg_nxt.min_position = wr_data;
        REG_MAX_POSITION: cfg_nxt.max_position = wr_data;
        REG_DEADBAND:     cfg_nxt.deadband     = wr_data[14:0];
        REG_RUN_SPEED:    cfg_nxt.run_speed    = wr_data[7:0];
        REG_MIN_DUTY:     cfg_nxt.min_duty     = wr_data[7:0];
        REG_MAX_DUTY:     cfg_nxt.max_duty     = wr_data[7:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_position <= 16'sh8000;
      cfg_r.max_position <= 16'sh7FFF;
      cfg_r.deadband     <= 15'd0;
      cfg_r.run_speed    <= 8'd0;
      cfg_r.min_duty     <= 8'd0;
      cfg_r.max_duty     <= 8'd255;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### design/epmc_ctrl.sv
`timescale 1ns / 1ps

module epmc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_en,
  input  epmc_pkg::in_item_t   item,
  input  epmc_pkg::cfg_t       cfg,
  output epmc_pkg::out_item_t  result
);
  import epmc_pkg::*;

  logic signed [15:0] pos_r,     pos_nxt;
  logic signed [15:0] tgt_r,     tgt_nxt;
  logic               first_r,   first_nxt;
  logic [7:0]         fwd_r,     fwd_nxt;
  logic [7:0]         rev_r,     rev_nxt;
  logic               settled_r, settled_nxt;

  logic signed [16:0] rel_sum;
  logic signed [16:0] pos_err;
  logic [16:0]        mag;
  logic [7:0]         duty_raw;
  logic [7:0]         duty;
  logic               hold_still;

  // Clamp a wide target into the position limits, low limit checked first
  function automatic logic signed [15:0] clamp_pos(
    input logic signed [16:0] x,
    input logic signed [15:0] lo,
    input logic signed [15:0] hi
  );
    logic signed [16:0] lo_w;
    logic signed [16:0] hi_w;
    lo_w = 17'(lo);
    hi_w = 17'(hi);
    if (x < lo_w) begin
      return lo;
    end else if (x > hi_w) begin
      return hi;
    end else begin
      return x[15:0];
    end
  endfunction

  // Error, duty and relative target terms
  always_comb begin
    rel_sum    = 17'(pos_r) + 17'(item.value);
    pos_err    = 17'(tgt_r) - 17'(pos_r);
    mag        = pos_err[16] ? 17'(-pos_err) : 17'(pos_err);
    hold_still = (cfg.run_speed == 8'd0) || (mag <= {2'b00, cfg.deadband});
    duty_raw   = first_r ? KICK_DUTY : cfg.run_speed;
    if (duty_raw < cfg.min_duty) begin
      duty = cfg.min_duty;
    end else if (duty_raw > cfg.max_duty) begin
      duty = cfg.max_duty;
    end else begin
      duty = duty_raw;
    end
  end

  // Apply the command
  always_comb begin
    pos_nxt     = pos_r;
    tgt_nxt     = tgt_r;
    first_nxt   = first_r;
    fwd_nxt     = fwd_r;
    rev_nxt     = rev_r;
    settled_nxt = settled_r;
    case (item.cmd)
      CMD_ENC_EDGE: begin
        pos_nxt = item.encoder_b ? pos_r + 16'sd1 : pos_r - 16'sd1;
      end
      CMD_RUN_TICK: begin
        if (hold_still) begin
          fwd_nxt     = 8'd0;
          rev_nxt     = 8'd0;
          first_nxt   = 1'b1;
          settled_nxt = 1'b1;
        end else begin
          first_nxt   = 1'b0;
          settled_nxt = 1'b0;
          fwd_nxt     = pos_err[16] ? 8'd0 : duty;
          rev_nxt     = pos_err[16] ? duty : 8'd0;
        end
      end
      CMD_MOVE_ABS:  tgt_nxt = clamp_pos(17'(item.value), cfg.min_position, cfg.max_position);
      CMD_MOVE_REL:  tgt_nxt = clamp_pos(rel_sum, cfg.min_position, cfg.max_position);
      CMD_GO_MIN: begin
        tgt_nxt = clamp_pos(17'(cfg.min_position), cfg.min_position, cfg.max_position);
      end
      CMD_GO_MAX: begin
        tgt_nxt = clamp_pos(17'(cfg.max_position), cfg.min_position, cfg.max_position);
      end
      CMD_RESET_POS: pos_nxt = 16'sd0;
      default: begin
        fwd_nxt   = 8'd0;
        rev_nxt   = 8'd0;
        first_nxt = 1'b1;
      end
    endcase
  end

  // Controller state, advanced once per transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= 16'sd0;
      tgt_r     <= 16'sd0;
      first_r   <= 1'b1;
      fwd_r     <= 8'd0;
      rev_r     <= 8'd0;
      settled_r <= 1'b1;
    end else if (item_en) begin
      pos_r     <= pos_nxt;
      tgt_r     <= tgt_nxt;
      first_r   <= first_nxt;
      fwd_r     <= fwd_nxt;
      rev_r     <= rev_nxt;
      settled_r <= settled_nxt;
    end
  end

  // Result reflects the state after this command
  always_comb begin
    result.duty_forward = fwd_nxt;
    result.duty_reverse = rev_nxt;
    result.position     = pos_nxt;
    result.at_target    = settled_nxt;
  end

endmodule

### test/tb_encoder_position_motor_controller_core.sv
`timescale 1ns / 1ps

module tb_encoder_position_motor_controller_core;
  import epmc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int          MAX_REPORTS  = 40;
  localparam int          PHASE_COUNT  = 8;
  localparam int          PHASE_ITEMS  = 250;
  localparam int          RUN_EDGES    = 200;
  localparam int          IDLE_PERCENT = 35;

  // Tracks controller state and the queue of positions/duties still owed by the block
  class motor_ctrl_scoreboard;
    logic signed [15:0] min_pos, max_pos, position, target;
    logic [14:0]        deadband;
    logic [7:0]         run_speed, min_duty, max_duty, fwd_duty, rev_duty;
    bit                 kick_pending, settled;
    out_item_t          expected_q[$];
    int                 errors;

    function new();
      min_pos      = 16'sh8000;
      max_pos      = 16'sh7fff;
      deadband     = '0;
      run_speed    = '0;
      min_duty     = '0;
      max_duty     = 8'hff;
      position     = '0;
      target       = '0;
      kick_pending = 1'b1;
      settled      = 1'b1;
      fwd_duty     = '0;
      rev_duty     = '0;
      errors       = 0;
    endfunction

    function void write_register(logic [2:0] idx, logic [15:0] data);
      case (idx)
        REG_MIN_POSITION: min_pos   = data;
        REG_MAX_POSITION: max_pos   = data;
        REG_DEADBAND:     deadband  = data[14:0];
        REG_RUN_SPEED:    run_speed = data[7:0];
        REG_MIN_DUTY:     min_duty  = data[7:0];
        REG_MAX_DUTY:     max_duty  = data[7:0];
        default: ;
      endcase
    endfunction

    // Low limit wins first, then high limit, even when the two are inverted
    function logic signed [15:0] clamp_target(int x);
      if (x < int'(min_pos)) return min_pos;
      if (x > int'(max_pos)) return max_pos;
      return 16'(x);
    endfunction

    // Advance the controller by one accepted command and queue its result
    function void note_command(in_item_t c);
      out_item_t want;
      int        err, mag, duty;
      case (c.cmd)
        CMD_ENC_EDGE:  position = c.encoder_b ? position + 16'sd1 : position - 16'sd1;
        CMD_RUN_TICK: begin
          err = int'(target) - int'(position);
          mag = (err < 0) ? -err : err;
          if (run_speed == 0 || mag <= int'(deadband)) begin
            fwd_duty     = '0;
            rev_duty     = '0;
            kick_pending = 1'b1;
            settled      = 1'b1;
          end else begin
            duty         = kick_pending ? int'(KICK_DUTY) : int'(run_speed);
            kick_pending = 1'b0;
            if (duty < int'(min_duty)) duty = int'(min_duty);
            else if (duty > int'(max_duty)) duty = int'(max_duty);
            settled = 1'b0;
            if (err < 0) begin
              fwd_duty = '0;
              rev_duty = 8'(duty);
            end else begin
              fwd_duty = 8'(duty);
              rev_duty = '0;
            end
          end
        end
        CMD_MOVE_ABS:  target = clamp_target(int'(c.value));
        CMD_MOVE_REL:  target = clamp_target(int'(position) + int'(c.value));
        CMD_GO_MIN:    target = clamp_target(int'(min_pos));
        CMD_GO_MAX:    target = clamp_target(int'(max_pos));
        CMD_RESET_POS: position = '0;
        CMD_STOP: begin
          fwd_duty     = '0;
          rev_duty     = '0;
          kick_pending = 1'b1;
        end
        default: ;
      endcase
      want.duty_forward = fwd_duty;
      want.duty_reverse = rev_duty;
      want.position     = position;
      want.at_target    = settled;
      expected_q.push_back(want);
    endfunction

    function void compare_field(string field, logic signed [15:0] want,
                                logic signed [15:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with none expected: expected nothing, actual %h",
                   $time, got);
        return;
      end
      want = expected_q.pop_front();
      compare_field("duty_forward", want.duty_forward, got.duty_forward);
      compare_field("duty_reverse", want.duty_reverse, got.duty_reverse);
      compare_field("position", want.position, got.position);
      compare_field("at_target", want.at_target, got.at_target);
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_item   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  bit          sender_idles   = 1'b1;
  bit          receiver_idles = 1'b1;
  int unsigned cycle_count    = 0;
  motor_ctrl_scoreboard board;

  encoder_position_motor_controller_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10;
    clk = 1'b1;
    #10;
    clk = 1'b0;
  end

  // Stall the result channel at random while idling is enabled
  always @(posedge clk) begin
    out_ready <= !receiver_idles || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Check every result transaction against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_item);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("encoder_position_motor_controller_core test failed");
      $finish;
    end
  end

  // Present one command, hold it until accepted, then record it
  task automatic send_command(in_item_t item);
    int gap;
    gap = 0;
    if (sender_idles)
      while ($urandom_range(99) < IDLE_PERCENT) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_command(item);
  endtask

  task automatic issue(logic [2:0] cmd, logic b, logic [15:0] value);
    in_item_t item;
    item.cmd       = cmd;
    item.encoder_b = b;
    item.value     = value;
    send_command(item);
  endtask

  // Hold off the sender until every expected result has arrived
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_register(idx, data);
  endtask

  // Write all six registers; unused upper data bits carry noise
  task automatic set_config(cfg_t c);
    write_reg(REG_MIN_POSITION, c.min_position);
    write_reg(REG_MAX_POSITION, c.max_position);
    write_reg(REG_DEADBAND, {1'($urandom), c.deadband});
    write_reg(REG_RUN_SPEED, {8'($urandom), c.run_speed});
    write_reg(REG_MIN_DUTY, {8'($urandom), c.min_duty});
    write_reg(REG_MAX_DUTY, {8'($urandom), c.max_duty});
    cfg_valid <= 1'b0;
  endtask

  // Mostly closed-loop traffic: edges follow the driven leg, targets near the shaft
  function automatic in_item_t random_command();
    in_item_t    item;
    int unsigned pick;
    item.cmd       = CMD_STOP;
    item.encoder_b = 1'($urandom);
    item.value     = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 32) begin
      item.cmd = CMD_ENC_EDGE;
      if ($urandom_range(9) != 0) begin
        if (board.fwd_duty != 0) item.encoder_b = 1'b1;
        else if (board.rev_duty != 0) item.encoder_b = 1'b0;
      end
    end else if (pick < 62) begin
      item.cmd = CMD_RUN_TICK;
    end else if (pick < 74) begin
      item.cmd = CMD_MOVE_ABS;
      case ($urandom_range(9))
        0:       item.value = 16'sh8000;
        1:       item.value = 16'sh7fff;
        2:       item.value = board.min_pos;
        3:       item.value = board.max_pos;
        4, 5:    ;
        default: item.value = 16'(int'(board.position) + int'($urandom_range(80)) - 40);
      endcase
    end else if (pick < 84) begin
      item.cmd = CMD_MOVE_REL;
      case ($urandom_range(9))
        0:       item.value = 16'sh8000;
        1:       item.value = 16'sh7fff;
        2, 3:    ;
        default: item.value = 16'(int'($urandom_range(32)) - 16);
      endcase
    end else if (pick < 88) begin
      item.cmd = CMD_GO_MIN;
    end else if (pick < 92) begin
      item.cmd = CMD_GO_MAX;
    end else if (pick < 95) begin
      item.cmd = CMD_RESET_POS;
    end
    return item;
  endfunction

  initial begin
    cfg_t cfg;
    board = new();

    // Reset
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: speed zero, so every tick settles
    issue(CMD_RUN_TICK, 1'($urandom), 16'($urandom));
    issue(CMD_ENC_EDGE, 1'b1, 16'($urandom));
    issue(CMD_ENC_EDGE, 1'b0, 16'($urandom));
    issue(CMD_ENC_EDGE, 1'b0, 16'($urandom));
    issue(CMD_MOVE_ABS, 1'($urandom), 16'sh7fff);
    issue(CMD_RUN_TICK, 1'($urandom), 16'($urandom));
    issue(CMD_MOVE_ABS, 1'($urandom), 16'sh8000);
    issue(CMD_MOVE_REL, 1'($urandom), 16'sh7fff);
    issue(CMD_MOVE_REL, 1'($urandom), 16'sh8000);
    issue(CMD_GO_MAX, 1'($urandom), 16'($urandom));
    issue(CMD_GO_MIN, 1'($urandom), 16'($urandom));
    issue(CMD_RESET_POS, 1'($urandom), 16'($urandom));
    issue(CMD_STOP, 1'($urandom), 16'($urandom));
    wait_for_results();

    // Narrow window: kick duty, duty limits, both legs, deadband settle
    cfg = '{-16'sd100, 16'sd100, 15'd3, 8'h80, 8'h10, 8'hf0};
    set_config(cfg);
    issue(CMD_MOVE_ABS, 1'($urandom), 16'sd1000);
    issue(CMD_RUN_TICK, 1'($urandom), 16'($urandom));
    issue(CMD_RUN_TICK, 1'($urandom), 16'($urandom));
    issue(CMD_MOVE_ABS, 1'($urandom), 16'sh8000);
    issue(CMD_RUN_TICK, 1'($urandom), 16'($urandom));
    issue(CMD_STOP, 1'($urandom), 16'($urandom));
    issue(CMD_RUN_TICK, 1'($urandom), 16'($urandom));
    issue(CMD_MOVE_REL, 1'($urandom), 16'sd2);
    issue(CMD_RUN_TICK, 1'($urandom), 16'($urandom));
    issue(CMD_MOVE_REL, 1'($urandom), 16'sd4);
    issue(CMD_RUN_TICK, 1'($urandom), 16'($urandom));
    issue(CMD_ENC_EDGE, 1'b1, 16'($urandom));
    wait_for_results();

    // Inverted position limits and inverted duty limits
    cfg = '{16'sd50, -16'sd50, 15'd0, 8'd10, 8'd20, 8'd5};
    set_config(cfg);
    issue(CMD_GO_MIN, 1'($urandom), 16'($urandom));
    issue(CMD_GO_MAX, 1'($urandom), 16'($urandom));
    issue(CMD_MOVE_ABS, 1'($urandom), 16'sd0);
    issue(CMD_RUN_TICK, 1'($urandom), 16'($urandom));
    issue(CMD_RUN_TICK, 1'($urandom), 16'($urandom));

    // Random phases, each with its own settings
    for (int p = 0; p < PHASE_COUNT; p++) begin
      wait_for_results();
      case ($urandom_range(7))
        0: begin
          cfg.min_position = 16'sh8000;
          cfg.max_position = 16'sh7fff;
        end
        1: begin
          cfg.min_position = 16'($urandom);
          cfg.max_position = 16'($urandom);
        end
        2: begin
          cfg.min_position = 16'sh7fff;
          cfg.max_position = 16'sh8000;
        end
        default: begin
          cfg.min_position = 16'(int'(board.position) - int'($urandom_range(120)));
          cfg.max_position = 16'(int'(board.position) + int'($urandom_range(120)));
        end
      endcase
      case ($urandom_range(5))
        0:       cfg.deadband = '0;
        1:       cfg.deadband = 15'h7fff;
        2:       cfg.deadband = 15'($urandom);
        default: cfg.deadband = 15'($urandom_range(6));
      endcase
      case ($urandom_range(5))
        0:       cfg.run_speed = '0;
        1:       cfg.run_speed = 8'hff;
        default: cfg.run_speed = 8'($urandom_range(255, 1));
      endcase
      case ($urandom_range(4))
        0: begin
          cfg.min_duty = 8'h00;
          cfg.max_duty = 8'hff;
        end
        1: begin
          cfg.min_duty = 8'hff;
          cfg.max_duty = 8'h00;
        end
        2: begin
          cfg.min_duty = 8'($urandom);
          cfg.max_duty = 8'($urandom);
        end
        default: begin
          cfg.min_duty = 8'($urandom_range(60));
          cfg.max_duty = 8'($urandom_range(255, 180));
        end
      endcase
      set_config(cfg);
      sender_idles   = (p == 0) || ($urandom_range(4) != 0);
      receiver_idles = (p == 0) || ($urandom_range(4) != 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(149) == 0) wait_for_results();
        send_command(random_command());
      end
    end

    // Walk the shaft down in a long back-to-back run with no idling on either side
    wait_for_results();
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    cfg = '{16'sh8000, 16'sh7fff, 15'd0, 8'd200, 8'd0, 8'hff};
    set_config(cfg);
    issue(CMD_RESET_POS, 1'($urandom), 16'($urandom));
    issue(CMD_MOVE_ABS, 1'($urandom), 16'sh7fff);
    issue(CMD_RUN_TICK, 1'($urandom), 16'($urandom));
    repeat (RUN_EDGES) issue(CMD_ENC_EDGE, 1'b0, 16'($urandom));
    issue(CMD_RUN_TICK, 1'($urandom), 16'($urandom));
    issue(CMD_MOVE_REL, 1'($urandom), 16'sh8000);
    issue(CMD_RUN_TICK, 1'($urandom), 16'($urandom));
    issue(CMD_MOVE_REL, 1'($urandom), 16'sh7fff);
    issue(CMD_ENC_EDGE, 1'b0, 16'($urandom));
    issue(CMD_MOVE_REL, 1'($urandom), 16'sh7fff);
    issue(CMD_MOVE_ABS, 1'($urandom), 16'sh8000);
    issue(CMD_RUN_TICK, 1'($urandom), 16'($urandom));
    issue(CMD_ENC_EDGE, 1'b1, 16'($urandom));
    issue(CMD_RUN_TICK, 1'($urandom), 16'($urandom));
    issue(CMD_RESET_POS, 1'($urandom), 16'($urandom));

    // Drain and report
    wait_for_results();
    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.expected_q.size() == 0)
      $display("encoder_position_motor_controller_core test passed");
    else
      $display("encoder_position_motor_controller_core test failed");
    $finish;
  end

endmodule
